// ===== design/bpr_pkg.sv =====
// Package for the bitmap pixel to RGBA2222 converter.
// Holds the configuration register map, the configuration struct and the
// channel packing helper. No dependencies.
package bpr_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int ROW_WIDTH_W = 13;
  localparam int COLOR_W     = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIXEL_FORMAT   = 3'd0,
    REG_RED_POSITION   = 3'd1,
    REG_GREEN_POSITION = 3'd2,
    REG_BLUE_POSITION  = 3'd3,
    REG_ALPHA_POSITION = 3'd4,
    REG_ROW_WIDTH      = 3'd5,
    REG_PAD_BYTES      = 3'd6
  } reg_index_t;

  localparam logic [1:0] FMT_PALETTE = 2'd0;
  localparam logic [1:0] FMT_THREE   = 2'd1;
  localparam logic [2:0] ALPHA_NONE  = 3'd4;
  localparam logic [7:0] ALPHA_FULL  = 8'hFF;
  localparam logic       REQ_PIXEL   = 1'b0;
  localparam logic       REQ_PALETTE = 1'b1;

  typedef struct packed {
    logic [1:0]             pixel_format;
    logic [1:0]             red_position;
    logic [1:0]             green_position;
    logic [1:0]             blue_position;
    logic [2:0]             alpha_position;
    logic [ROW_WIDTH_W-1:0] row_width;
    logic [1:0]             pad_bytes;
  } cfg_t;

  // Fields carried from the gather stage to the output stage.
  typedef struct packed {
    logic       from_palette;
    logic       index_oob;
    logic [7:0] packed_direct;
    logic       row_end;
  } stage_t;

  // Each channel keeps its top two bits.
  function automatic logic [7:0] pack_rgba(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [7:0] a);
    return {a[7:6], b[7:6], g[7:6], r[7:6]};
  endfunction

endpackage

// ===== design/bpr_ifs.sv =====
// Channel interfaces of the bitmap pixel to RGBA2222 converter:
// pixel input, packed pixel output and configuration write channel.
// Depends on bpr_pkg.
interface bpr_in_if;
  import bpr_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [7:0]         data_byte;
  logic [7:0]         palette_index;
  logic [COLOR_W-1:0] palette_color;
  modport source (output valid, req_type, data_byte, palette_index, palette_color,
                  input ready);
  modport sink (input valid, req_type, data_byte, palette_index, palette_color,
                output ready);
endinterface

interface bpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_pixel;
  logic       row_end;
  modport source (output valid, packed_pixel, row_end, input ready);
  modport sink (input valid, packed_pixel, row_end, output ready);
endinterface

interface bpr_cfg_if;
  import bpr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== design/bmp_pixel_to_rgba2222.sv =====
// Bitmap pixel-data to RGBA2222 converter, top level.
// Channels: pixel_in takes one request per cycle while its ready is high,
// either a raw pixel-data byte or a palette entry write; pixel_out gives one
// packed byte per finished pixel (alpha 7:6, blue 5:4, green 3:2, red 1:0)
// with row_end on the last pixel of each row; cfg writes the format, channel
// positions, row width and row padding registers, and the user must write
// them only while the block is idle; the block itself does not enforce it.
// Throughput: one request per cycle while pixel_in.ready is high. The byte
// that completes a pixel is captured in the gather register, where the
// palette RAM read also lands; the output register then takes its result.
// Reset clears the gather, column and padding state and loads the register
// defaults; the palette RAM is not cleared and its entries are undefined
// until written. When the receiver stalls, the output register holds its
// result, one more result waits in the gather register, and pixel_in.ready
// falls only when both are full and pixel_out.ready is low.
// Depends on bpr_pkg, bpr_ifs, bpr_ram, bpr_cfg_regs, bpr_front, bpr_back.
module bmp_pixel_to_rgba2222 #(
  parameter int MAX_ROW_WIDTH = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  bpr_in_if.sink    pixel_in,
  bpr_out_if.source pixel_out,
  bpr_cfg_if.sink   cfg
);
  import bpr_pkg::*;

  cfg_t                regs;
  stage_t              stage;
  logic                stage_valid;
  logic                stage_take;
  logic [COLOR_W-1:0]  pal_rdata;

  bpr_cfg_regs u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .regs(regs)
  );

  bpr_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pixel_in),
    .regs       (regs),
    .stage_take (stage_take),
    .stage_valid(stage_valid),
    .stage      (stage),
    .pal_rdata  (pal_rdata)
  );

  bpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .stage_valid(stage_valid),
    .stage      (stage),
    .pal_rdata  (pal_rdata),
    .stage_take (stage_take),
    .pixel_out  (pixel_out)
  );

endmodule

// ===== design/bpr_ram.sv =====
// Generic simple dual-port RAM with registered read.
// One write port and one read port. No dependencies.
module bpr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bpr_cfg_regs.sv =====
// Configuration register file of the bitmap pixel to RGBA2222 converter.
// Decodes writes on the configuration channel. Depends on bpr_pkg, bpr_ifs.
module bpr_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  bpr_cfg_if.sink      cfg,
  output bpr_pkg::cfg_t regs
);
  import bpr_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pixel_format   <= FMT_THREE;
      regs.red_position   <= 2'd2;
      regs.green_position <= 2'd1;
      regs.blue_position  <= 2'd0;
      regs.alpha_position <= ALPHA_NONE;
      regs.row_width      <= ROW_WIDTH_W'(1);
      regs.pad_bytes      <= 2'd0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_PIXEL_FORMAT:   regs.pixel_format   <= cfg.wr_data[1:0];
        REG_RED_POSITION:   regs.red_position   <= cfg.wr_data[1:0];
        REG_GREEN_POSITION: regs.green_position <= cfg.wr_data[1:0];
        REG_BLUE_POSITION:  regs.blue_position  <= cfg.wr_data[1:0];
        REG_ALPHA_POSITION: regs.alpha_position <= cfg.wr_data[2:0];
        REG_ROW_WIDTH:      regs.row_width      <= cfg.wr_data[ROW_WIDTH_W-1:0];
        REG_PAD_BYTES:      regs.pad_bytes      <= cfg.wr_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bpr_front.sv =====
// Input stage of the bitmap pixel to RGBA2222 converter: byte gathering,
// row and padding counters, palette RAM writes and reads.
// Depends on bpr_pkg, bpr_ifs and bpr_ram.
module bpr_front #(
  parameter int MAX_ROW_WIDTH = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  bpr_in_if.sink                         pixel_in,
  input  bpr_pkg::cfg_t                  regs,
  input  logic                           stage_take,
  output logic                           stage_valid,
  output bpr_pkg::stage_t                stage,
  output logic [bpr_pkg::COLOR_W-1:0]    pal_rdata
);
  import bpr_pkg::*;

  localparam int AW   = $clog2(PALETTE_DEPTH);
  localparam int CW   = $clog2(MAX_ROW_WIDTH);
  localparam int CMPW = ((CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W) + 1;

  logic [31:0]   gathered;
  logic [31:0]   gathered_next;
  logic [1:0]    byte_in_pixel;
  logic [CW-1:0] column_count;
  logic [1:0]    pad_left;

  logic          load_ok;
  logic          accept;
  logic          is_pixel;
  logic          pixel_live;
  logic          fmt_palette;
  logic [2:0]    bytes_per_pixel;
  logic [2:0]    byte_count;
  logic          pixel_done;
  logic [7:0]    alpha_src;
  logic [7:0]    packed_direct;
  logic [CMPW-1:0] width_raw;
  logic [CMPW-1:0] width_eff;
  logic            last_col;
  logic            pal_we;

  // A new request may enter whenever the stage register is empty or drains now.
  assign load_ok        = !stage_valid || stage_take;
  assign pixel_in.ready = load_ok;
  assign accept         = pixel_in.valid && load_ok;
  assign is_pixel       = accept && (pixel_in.req_type == REQ_PIXEL);
  assign pixel_live     = is_pixel && (pad_left == 2'd0);

  assign fmt_palette     = (regs.pixel_format == FMT_PALETTE);
  assign bytes_per_pixel = (regs.pixel_format == FMT_THREE) ? 3'd3 : 3'd4;
  assign byte_count      = {1'b0, byte_in_pixel} + 3'd1;
  assign pixel_done      = pixel_live && (fmt_palette || byte_count >= bytes_per_pixel);

  assign gathered_next = gathered | (32'(pixel_in.data_byte) << {byte_in_pixel, 3'b000});

  assign alpha_src = (regs.alpha_position >= ALPHA_NONE) ? ALPHA_FULL :
                     gathered_next[{regs.alpha_position[1:0], 3'b000} +: 8];
  assign packed_direct = pack_rgba(gathered_next[{regs.red_position, 3'b000} +: 8],
                                   gathered_next[{regs.green_position, 3'b000} +: 8],
                                   gathered_next[{regs.blue_position, 3'b000} +: 8],
                                   alpha_src);

  // Width zero acts as one; widths above the maximum saturate.
  always_comb begin
    width_raw = CMPW'(regs.row_width);
    if (width_raw == '0) begin
      width_eff = CMPW'(1);
    end else if (width_raw > CMPW'(MAX_ROW_WIDTH)) begin
      width_eff = CMPW'(MAX_ROW_WIDTH);
    end else begin
      width_eff = width_raw;
    end
  end

  assign last_col = (CMPW'(column_count) + CMPW'(1)) >= width_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      gathered      <= '0;
      byte_in_pixel <= '0;
      column_count  <= '0;
      pad_left      <= '0;
      stage_valid   <= 1'b0;
    end else begin
      if (is_pixel && (pad_left != 2'd0)) begin
        pad_left <= pad_left - 2'd1;
      end
      if (pixel_live && !fmt_palette) begin
        if (pixel_done) begin
          gathered      <= '0;
          byte_in_pixel <= '0;
        end else begin
          gathered      <= gathered_next;
          byte_in_pixel <= byte_count[1:0];
        end
      end
      if (pixel_done) begin
        if (last_col) begin
          column_count <= '0;
          pad_left     <= regs.pad_bytes;
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
      if (load_ok) begin
        stage_valid <= pixel_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      stage.from_palette  <= fmt_palette;
      stage.index_oob     <= {1'b0, pixel_in.data_byte} >= 9'(PALETTE_DEPTH);
      stage.packed_direct <= packed_direct;
      stage.row_end       <= last_col;
    end
  end

  assign pal_we = accept && (pixel_in.req_type == REQ_PALETTE) &&
                  ({1'b0, pixel_in.palette_index} < 9'(PALETTE_DEPTH));

  bpr_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(pixel_in.palette_index[AW-1:0]),
    .wdata(pixel_in.palette_color),
    .re   (is_pixel),
    .raddr(pixel_in.data_byte[AW-1:0]),
    .rdata(pal_rdata)
  );

endmodule

// ===== design/bpr_back.sv =====
// Output stage of the bitmap pixel to RGBA2222 converter: selects the
// palette or gathered pixel, black for an out-of-range index, and
// holds it in the output register. Depends on bpr_pkg and bpr_ifs.
module bpr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        stage_valid,
  input  bpr_pkg::stage_t             stage,
  input  logic [bpr_pkg::COLOR_W-1:0] pal_rdata,
  output logic                        stage_take,
  bpr_out_if.source                   pixel_out
);
  import bpr_pkg::*;

  logic [7:0] packed_next;

  // Palette colors are stored blue in the low byte, red in the high byte.
  always_comb begin
    if (!stage.from_palette) begin
      packed_next = stage.packed_direct;
    end else if (stage.index_oob) begin
      packed_next = pack_rgba(8'h00, 8'h00, 8'h00, ALPHA_FULL);
    end else begin
      packed_next = pack_rgba(pal_rdata[23:16], pal_rdata[15:8], pal_rdata[7:0],
                              ALPHA_FULL);
    end
  end

  assign stage_take = stage_valid && (!pixel_out.valid || pixel_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (stage_take) begin
      pixel_out.valid <= 1'b1;
    end else if (pixel_out.ready) begin
      pixel_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take) begin
      pixel_out.packed_pixel <= packed_next;
      pixel_out.row_end      <= stage.row_end;
    end
  end

endmodule

// ===== tb/bmp_pixel_to_rgba2222_tb.sv =====
// Testbench for bmp_pixel_to_rgba2222: directed and random bitmap byte traffic
// checked against an in-bench packer model, with random idling on every channel.
// Depends on bpr_pkg, bpr_ifs and the bmp_pixel_to_rgba2222 top level.
module bmp_pixel_to_rgba2222_tb;
  import bpr_pkg::*;

  localparam int MAX_ROW_WIDTH = 4096;
  localparam int PALETTE_DEPTH = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 114;
  localparam int MAX_REPORTS = 30;
  localparam logic [1:0] FMT_FOUR = 2'd2;
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [7:0] pixel;
    logic       row_end;
  } pixel_result_t;

  logic clk;
  logic rst;

  bpr_in_if pixel_in ();
  bpr_out_if pixel_out ();
  bpr_cfg_if cfg ();

  bmp_pixel_to_rgba2222 dut (
    .clk(clk),
    .rst(rst),
    .pixel_in(pixel_in),
    .pixel_out(pixel_out),
    .cfg(cfg)
  );

  // Model state of the packer.
  cfg_t settings;
  logic [COLOR_W-1:0] palette_copy [PALETTE_DEPTH];
  bit palette_written [PALETTE_DEPTH];
  logic [7:0] written_entries[$];
  logic [31:0] pixel_bytes = '0;
  int bytes_held = 0;
  int column_pos = 0;
  int pad_remaining = 0;

  pixel_result_t pending_pixels[$];

  bit no_gaps = 1'b0;
  int hold_cycles = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int palette_sent = 0;
  int writes_done = 0;
  int results_checked = 0;
  int rows_closed = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] byte_at(input logic [1:0] pos);
    return pixel_bytes[pos*8 +: 8];
  endfunction

  // Advances the model by one request; returns 1 when a packed pixel comes out.
  function automatic bit convert_request(input logic req, input logic [7:0] data,
                                         input logic [7:0] pidx,
                                         input logic [COLOR_W-1:0] pcol,
                                         output pixel_result_t res);
    logic [COLOR_W-1:0] color;
    logic [7:0] r, g, b, a;
    int bpp;
    int width;
    res = '{pixel: 8'h00, row_end: 1'b0};
    if (req == REQ_PALETTE) begin
      palette_copy[pidx] = pcol;
      if (!palette_written[pidx]) begin
        palette_written[pidx] = 1'b1;
        written_entries.push_back(pidx);
      end
      return 1'b0;
    end
    if (pad_remaining != 0) begin
      pad_remaining--;
      return 1'b0;
    end
    if (settings.pixel_format == FMT_PALETTE) begin
      color = palette_copy[data];
      r = color[23:16];
      g = color[15:8];
      b = color[7:0];
      a = ALPHA_FULL;
    end else begin
      bpp = (settings.pixel_format == FMT_THREE) ? 3 : 4;
      pixel_bytes[bytes_held*8 +: 8] = data;
      if (bytes_held + 1 < bpp) begin
        bytes_held++;
        return 1'b0;
      end
      r = byte_at(settings.red_position);
      g = byte_at(settings.green_position);
      b = byte_at(settings.blue_position);
      a = (settings.alpha_position >= ALPHA_NONE) ? ALPHA_FULL
                                                  : byte_at(settings.alpha_position[1:0]);
      pixel_bytes = '0;
      bytes_held = 0;
    end
    width = settings.row_width;
    if (width == 0) width = 1;
    if (width > MAX_ROW_WIDTH) width = MAX_ROW_WIDTH;
    res.pixel = {a[7:6], b[7:6], g[7:6], r[7:6]};
    res.row_end = (column_pos + 1 >= width);
    if (res.row_end) begin
      column_pos = 0;
      pad_remaining = settings.pad_bytes;
    end else begin
      column_pos++;
    end
    return 1'b1;
  endfunction

  // In palette mode a byte that is not padding must name an entry already loaded.
  function automatic logic [7:0] next_pixel_byte();
    if (settings.pixel_format == FMT_PALETTE && pad_remaining == 0 &&
        written_entries.size() != 0)
      return written_entries[$urandom_range(0, written_entries.size() - 1)];
    return 8'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_checked, what, got, want);
  endtask

  task automatic send_request(input logic req, input logic [7:0] data,
                              input logic [7:0] pidx, input logic [COLOR_W-1:0] pcol);
    int gap;
    pixel_result_t res;
    gap = pick_gap();
    cfg.valid <= 1'b0;
    if (gap > 0) begin
      pixel_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_in.valid <= 1'b1;
    pixel_in.req_type <= req;
    pixel_in.data_byte <= data;
    pixel_in.palette_index <= pidx;
    pixel_in.palette_color <= pcol;
    @(posedge clk);
    while (!pixel_in.ready) @(posedge clk);
    if (convert_request(req, data, pidx, pcol, res)) pending_pixels.push_back(res);
    if (req == REQ_PALETTE) palette_sent++;
    else pixels_sent++;
  endtask

  task automatic send_pixel(input logic [7:0] data);
    send_request(REQ_PIXEL, data, 8'($urandom()), 24'($urandom()));
  endtask

  task automatic send_palette(input logic [7:0] pidx, input logic [COLOR_W-1:0] pcol);
    send_request(REQ_PALETTE, 8'($urandom()), pidx, pcol);
  endtask

  // Bits above the field width are filled with noise; the register must drop them.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value,
                           input int nbits);
    int gap;
    logic [31:0] raw;
    logic [CFG_DATA_W-1:0] data;
    raw = ($urandom() << nbits) | (32'(value) & ((32'd1 << nbits) - 1));
    data = raw[CFG_DATA_W-1:0];
    gap = pick_gap();
    if (gap > 0) begin
      cfg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg.valid <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wr_data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_PIXEL_FORMAT:   settings.pixel_format = data[1:0];
      REG_RED_POSITION:   settings.red_position = data[1:0];
      REG_GREEN_POSITION: settings.green_position = data[1:0];
      REG_BLUE_POSITION:  settings.blue_position = data[1:0];
      REG_ALPHA_POSITION: settings.alpha_position = data[2:0];
      REG_ROW_WIDTH:      settings.row_width = data[ROW_WIDTH_W-1:0];
      REG_PAD_BYTES:      settings.pad_bytes = data[1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // Waits until every expected pixel has come out and the pipeline has emptied.
  task automatic drain_pipeline();
    pixel_in.valid <= 1'b0;
    cfg.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_settings();
    // Three bytes per pixel, blue first, no alpha, one pixel per row.
    send_pixel(8'h80);
    send_pixel(8'h40);
    send_pixel(8'hC0);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
  endtask

  task automatic test_palette_lookup();
    drain_pipeline();
    write_reg(REG_PIXEL_FORMAT, FMT_PALETTE, 2);
    write_reg(REG_ROW_WIDTH, 2, 13);
    write_reg(REG_PAD_BYTES, 3, 2);
    send_palette(8'h00, 24'h000000);
    send_palette(8'hFF, 24'hFFFFFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    // Three pad bytes follow the row end and must be dropped.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    // A rewrite read back by the very next request.
    send_palette(8'hFF, 24'h4080C0);
    send_pixel(8'hFF);
  endtask

  task automatic test_channel_positions();
    drain_pipeline();
    write_reg(REG_PIXEL_FORMAT, FMT_FOUR, 2);
    write_reg(REG_RED_POSITION, 3, 2);
    write_reg(REG_GREEN_POSITION, 0, 2);
    write_reg(REG_BLUE_POSITION, 1, 2);
    write_reg(REG_ALPHA_POSITION, 2, 3);
    write_reg(REG_PAD_BYTES, 0, 2);
    send_pixel(8'h40);
    send_pixel(8'h80);
    send_pixel(8'h00);
    send_pixel(8'hC0);
  endtask

  task automatic test_odd_settings();
    drain_pipeline();
    // Spare format code gathers four bytes; alpha code 7 means no alpha.
    write_reg(REG_PIXEL_FORMAT, FMT_SPARE, 2);
    write_reg(REG_ALPHA_POSITION, 7, 3);
    write_reg(REG_ROW_WIDTH, 0, 13);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    drain_pipeline();
    // In three-byte mode the fourth byte position always reads zero.
    write_reg(REG_PIXEL_FORMAT, FMT_THREE, 2);
    write_reg(REG_ALPHA_POSITION, 3, 3);
    write_reg(REG_UNUSED, 13'h1FFF, 13);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
  endtask

  task automatic test_format_switch();
    drain_pipeline();
    write_reg(REG_PIXEL_FORMAT, FMT_FOUR, 2);
    write_reg(REG_ALPHA_POSITION, ALPHA_NONE, 3);
    write_reg(REG_RED_POSITION, 2, 2);
    write_reg(REG_GREEN_POSITION, 1, 2);
    write_reg(REG_BLUE_POSITION, 0, 2);
    send_pixel(8'h11);
    send_pixel(8'hC2);
    drain_pipeline();
    write_reg(REG_PIXEL_FORMAT, FMT_THREE, 2);
    send_pixel(8'h83);
    drain_pipeline();
    write_reg(REG_PIXEL_FORMAT, FMT_FOUR, 2);
    send_pixel(8'h44);
    send_pixel(8'h95);
    send_pixel(8'hE6);
    drain_pipeline();
    write_reg(REG_PIXEL_FORMAT, FMT_THREE, 2);
    send_pixel(8'h77);
  endtask

  task automatic test_longest_row();
    int n;
    drain_pipeline();
    no_gaps = 1'b1;
    write_reg(REG_PIXEL_FORMAT, FMT_PALETTE, 2);
    write_reg(REG_ROW_WIDTH, MAX_ROW_WIDTH, 13);
    write_reg(REG_PAD_BYTES, 2, 2);
    for (n = 0; n < 60; n++) send_pixel(next_pixel_byte());
    drain_pipeline();
    // Widths above the maximum saturate, so the long row keeps going.
    write_reg(REG_ROW_WIDTH, 13'h1FFF, 13);
    for (n = 0; n < 60; n++) send_pixel(next_pixel_byte());
    drain_pipeline();
    // Cut to twelve bits this width would be five and end the row at once.
    write_reg(REG_ROW_WIDTH, MAX_ROW_WIDTH + 5, 13);
    for (n = 0; n < 20; n++) send_pixel(next_pixel_byte());
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    int n;
    drain_pipeline();
    write_reg(REG_PIXEL_FORMAT, FMT_PALETTE, 2);
    write_reg(REG_ROW_WIDTH, 5, 13);
    write_reg(REG_PAD_BYTES, 0, 2);
    no_gaps = 1'b1;
    hold_cycles = HOLD_CYCLES;
    for (n = 0; n < 40; n++) send_pixel(next_pixel_byte());
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase, n, roll, width;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pipeline();
      no_gaps = (phase % 4 == 3);
      roll = $urandom_range(0, 99);
      if (roll < 8) width = 0;
      else if (roll < 75) width = $urandom_range(1, 8);
      else if (roll < 95) width = $urandom_range(9, 40);
      else width = $urandom_range(41, 200);
      write_reg(REG_PIXEL_FORMAT, ($urandom_range(0, 9) == 0) ? FMT_SPARE
                                                              : $urandom_range(0, 2), 2);
      write_reg(REG_RED_POSITION, $urandom_range(0, 3), 2);
      write_reg(REG_GREEN_POSITION, $urandom_range(0, 3), 2);
      write_reg(REG_BLUE_POSITION, $urandom_range(0, 3), 2);
      write_reg(REG_ALPHA_POSITION, $urandom_range(0, 7), 3);
      write_reg(REG_ROW_WIDTH, width, 13);
      write_reg(REG_PAD_BYTES, $urandom_range(0, 3), 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 12)
          send_palette(8'($urandom()), 24'($urandom()));
        else
          send_pixel(next_pixel_byte());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin : output_receiver
    int stall_left;
    stall_left = 0;
    pixel_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        pixel_out.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        pixel_out.ready <= 1'b0;
        stall_left--;
      end else begin
        pixel_out.ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  initial begin : result_checker
    pixel_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && pixel_out.valid === 1'b1 && pixel_out.ready === 1'b1) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("result with none expected", pixel_out.packed_pixel, 0);
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_out.packed_pixel !== want.pixel)
            report_mismatch("packed_pixel", pixel_out.packed_pixel, want.pixel);
          if (pixel_out.row_end !== want.row_end)
            report_mismatch("row_end", pixel_out.row_end, want.row_end);
          if (want.row_end) rows_closed++;
          results_checked++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pixel_in.valid === 1'b1 && pixel_in.ready === 1'b1) ||
          (pixel_out.valid === 1'b1 && pixel_out.ready === 1'b1) ||
          (cfg.valid === 1'b1 && cfg.ready === 1'b1))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("bmp_pixel_to_rgba2222 regression: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    pixel_in.valid <= 1'b0;
    pixel_in.req_type <= REQ_PIXEL;
    pixel_in.data_byte <= '0;
    pixel_in.palette_index <= '0;
    pixel_in.palette_color <= '0;
    cfg.valid <= 1'b0;
    cfg.reg_index <= REG_PIXEL_FORMAT;
    cfg.wr_data <= '0;
    settings = '{pixel_format: FMT_THREE, red_position: 2'd2, green_position: 2'd1,
                 blue_position: 2'd0, alpha_position: ALPHA_NONE,
                 row_width: 13'd1, pad_bytes: 2'd0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_palette_lookup();
    test_channel_positions();
    test_odd_settings();
    test_format_switch();
    test_longest_row();
    test_backpressure();
    test_random_traffic();
    drain_pipeline();

    $display("Sent %0d pixel bytes, %0d palette loads and %0d register writes.",
             pixels_sent, palette_sent, writes_done);
    $display("Checked %0d packed pixels, %0d of them closing a row; %0d mismatches.",
             results_checked, rows_closed, mismatches);
    if (mismatches == 0)
      $display("bmp_pixel_to_rgba2222 regression: pass");
    else
      $display("bmp_pixel_to_rgba2222 regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/bpr_pkg.sv
design/bpr_ifs.sv
design/bpr_ram.sv
design/bpr_cfg_regs.sv
design/bpr_front.sv
design/bpr_back.sv
design/bmp_pixel_to_rgba2222.sv
tb/bmp_pixel_to_rgba2222_tb.sv
